[src/fra_pkg.sv]
// ----------------------------------------------------------------------------
// fra_pkg: shared types and constants of the frame reassembler
// Beat payloads, frame geometry, ASCII codes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package fra_pkg;

  // Frame geometry
  localparam int unsigned PayloadBytes = 10;
  localparam int unsigned MaxFrames    = 16;
  localparam int unsigned HdrLen       = 4;
  localparam int unsigned StoreSize    = PayloadBytes * MaxFrames;
  localparam int unsigned PosLimit     = HdrLen + PayloadBytes + 1;
  localparam int unsigned PosW         = $clog2(PosLimit + 1);
  localparam int unsigned CntW         = $clog2(PayloadBytes + 1);
  localparam int unsigned FrameW       = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
  localparam int unsigned StoreAw      = $clog2(StoreSize);
  localparam int unsigned HdrW         = 7;
  localparam int unsigned LenW         = 8;
  localparam int unsigned DecimalBase  = 10;

  // ASCII codes
  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiNine = 8'h39;
  localparam logic [7:0] AsciiDot  = 8'h2E;
  localparam logic [7:0] AsciiOne  = 8'h31;

  // Result status codes
  localparam logic [2:0] StIncomplete = 3'd0;
  localparam logic [2:0] StComplete   = 3'd1;
  localparam logic [2:0] StEndTurn    = 3'd2;
  localparam logic [2:0] StShutdown   = 3'd3;
  localparam logic [2:0] StMalformed  = 3'd4;
  localparam logic [2:0] StRead       = 3'd5;

  // Input beat
  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] read_address;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [2:0] status;
    logic [4:0] frame_count;
    logic [7:0] message_length;
    logic [7:0] read_data;
  } out_t;

  // Store write request from the frame parser
  typedef struct packed {
    logic               we;
    logic [StoreAw-1:0] addr;
    logic [7:0]         data;
  } wr_t;

  // End-of-frame outcome from the frame parser
  typedef struct packed {
    logic       done;
    logic [2:0] status;
    logic [4:0] frame_count;
    logic [7:0] message_length;
  } frame_res_t;

endpackage

`default_nettype wire

[src/fra_ram.sv]
// ----------------------------------------------------------------------------
// fra_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 160,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/fra_frame.sv]
// ----------------------------------------------------------------------------
// fra_frame: header parser and frame bookkeeping
// Parses the ASCII header, steers payload bytes to the store, tracks the
// received frames and decides the outcome at the end of each frame.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_frame (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   beat_i,
  input  wire logic [7:0]             data_byte_i,
  input  wire logic                   last_byte_i,
  output fra_pkg::wr_t                wr_o,
  output fra_pkg::frame_res_t         res_o
);

  logic [fra_pkg::PosW-1:0]      pos_q, pos_d;
  logic [fra_pkg::HdrW-1:0]      total_q, total_d;
  logic [fra_pkg::HdrW-1:0]      index_q, index_d;
  logic                          bad_q, bad_d;
  logic                          ended_q, ended_d;
  logic                          dot_q, dot_d;
  logic                          one_q, one_d;
  logic [fra_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic [fra_pkg::MaxFrames-1:0] recv_q, recv_d;
  logic [fra_pkg::CntW-1:0]      flen_q [fra_pkg::MaxFrames];

  logic [7:0]                    digit;
  logic [fra_pkg::PosW-1:0]      slot;
  logic                          hdr_ok_q, hdr_ok_d;
  logic [fra_pkg::MaxFrames-1:0] recv_mark;
  logic [fra_pkg::MaxFrames-1:0] in_msg;
  logic                          all_in;
  logic [fra_pkg::FrameW-1:0]    idx_cur, idx_new, last_idx;
  logic [fra_pkg::CntW-1:0]      last_len;
  logic                          flen_we;

  function automatic logic hdr_ok(logic [fra_pkg::HdrW-1:0] total,
                                  logic [fra_pkg::HdrW-1:0] index, logic bad);
    hdr_ok = !bad && (total != '0) &&
             (total <= fra_pkg::HdrW'(fra_pkg::MaxFrames)) && (index < total);
  endfunction

  assign digit    = data_byte_i - fra_pkg::AsciiZero;
  assign slot     = pos_q - fra_pkg::PosW'(fra_pkg::HdrLen);
  assign hdr_ok_q = hdr_ok(total_q, index_q, bad_q);
  assign idx_cur  = index_q[fra_pkg::FrameW-1:0];

  // Take one frame byte: header digits, payload flags and store write
  always_comb begin
    pos_d   = pos_q;
    total_d = total_q;
    index_d = index_q;
    bad_d   = bad_q;
    ended_d = ended_q;
    dot_d   = dot_q;
    one_d   = one_q;
    cnt_d   = cnt_q;
    wr_o.we   = 1'b0;
    wr_o.addr = fra_pkg::StoreAw'(idx_cur) * fra_pkg::StoreAw'(fra_pkg::PayloadBytes) +
                fra_pkg::StoreAw'(slot);
    wr_o.data = data_byte_i;
    if (beat_i && (pos_q < fra_pkg::PosW'(fra_pkg::PosLimit))) begin
      if (pos_q < fra_pkg::PosW'(fra_pkg::HdrLen)) begin
        if ((data_byte_i < fra_pkg::AsciiZero) || (data_byte_i > fra_pkg::AsciiNine)) begin
          bad_d = 1'b1;
        end else begin
          unique case (pos_q[1:0])
            2'd0: total_d = fra_pkg::HdrW'(digit[3:0]) * fra_pkg::HdrW'(fra_pkg::DecimalBase);
            2'd1: total_d = total_q + fra_pkg::HdrW'(digit[3:0]);
            2'd2: index_d = fra_pkg::HdrW'(digit[3:0]) * fra_pkg::HdrW'(fra_pkg::DecimalBase);
            2'd3: index_d = index_q + fra_pkg::HdrW'(digit[3:0]);
          endcase
        end
      end else if (!ended_q) begin
        if (data_byte_i == 8'h00) begin
          ended_d = 1'b1;
        end else begin
          if ((slot == fra_pkg::PosW'(0)) && (data_byte_i == fra_pkg::AsciiDot)) begin
            dot_d = 1'b1;
          end
          if ((slot == fra_pkg::PosW'(1)) && (data_byte_i == fra_pkg::AsciiOne)) begin
            one_d = 1'b1;
          end
          if (slot < fra_pkg::PosW'(fra_pkg::PayloadBytes)) begin
            wr_o.we = hdr_ok_q;
            cnt_d   = cnt_q + fra_pkg::CntW'(1);
          end
        end
      end
      pos_d = pos_q + fra_pkg::PosW'(1);
    end
  end

  assign hdr_ok_d = hdr_ok(total_d, index_d, bad_d);
  assign idx_new  = index_d[fra_pkg::FrameW-1:0];
  assign last_idx = fra_pkg::FrameW'(total_d - fra_pkg::HdrW'(1));

  // Mark this frame and check the frames of the message
  always_comb begin
    for (int i = 0; i < fra_pkg::MaxFrames; i++) begin
      recv_mark[i] = recv_q[i] | (idx_new == fra_pkg::FrameW'(i));
      in_msg[i]    = fra_pkg::HdrW'(i) < total_d;
    end
  end
  assign all_in   = &(recv_mark | ~in_msg);
  assign last_len = (last_idx == idx_new) ? cnt_d : flen_q[last_idx];

  // Decide the frame outcome
  always_comb begin
    res_o.done           = beat_i && last_byte_i;
    res_o.status         = fra_pkg::StMalformed;
    res_o.frame_count    = '0;
    res_o.message_length = '0;
    recv_d               = recv_q;
    flen_we              = 1'b0;
    if (res_o.done && (pos_d >= fra_pkg::PosW'(fra_pkg::HdrLen)) && hdr_ok_d) begin
      res_o.frame_count = 5'(total_d);
      flen_we           = 1'b1;
      recv_d            = recv_mark;
      if (dot_d) begin
        res_o.status = one_d ? fra_pkg::StEndTurn : fra_pkg::StShutdown;
      end else if (all_in) begin
        res_o.status         = fra_pkg::StComplete;
        res_o.message_length = fra_pkg::LenW'(last_idx) *
                               fra_pkg::LenW'(fra_pkg::PayloadBytes) +
                               fra_pkg::LenW'(last_len);
        recv_d               = '0;
      end else begin
        res_o.status = fra_pkg::StIncomplete;
      end
    end
  end

  // Advance frame state, drop it at the end of a frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      total_q <= '0;
      index_q <= '0;
      bad_q   <= 1'b0;
      ended_q <= 1'b0;
      dot_q   <= 1'b0;
      one_q   <= 1'b0;
      cnt_q   <= '0;
      recv_q  <= '0;
    end else if (beat_i) begin
      recv_q <= recv_d;
      if (last_byte_i) begin
        pos_q   <= '0;
        total_q <= '0;
        index_q <= '0;
        bad_q   <= 1'b0;
        ended_q <= 1'b0;
        dot_q   <= 1'b0;
        one_q   <= 1'b0;
        cnt_q   <= '0;
      end else begin
        pos_q   <= pos_d;
        total_q <= total_d;
        index_q <= index_d;
        bad_q   <= bad_d;
        ended_q <= ended_d;
        dot_q   <= dot_d;
        one_q   <= one_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  // Record the frame length
  always_ff @(posedge clk_i) begin
    if (flen_we) begin
      flen_q[idx_new] <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[src/frame_reassembler_ascii_header.sv]
// ----------------------------------------------------------------------------
// frame_reassembler_ascii_header: frame reassembler with ASCII decimal header
// Collects frame payloads into a message store and reports frame outcomes.
// ----------------------------------------------------------------------------
// Result path: an accepted beat reaches its result beat through the store read
//   stage, then the output register; frame bytes without the last mark give none.
// Throughput: one beat per cycle while the result channel is not stalled.
// Reset: control state and frame marks clear at once; the message store and
//   the frame lengths are undefined until written, with no clearing pass.
`default_nettype none

module frame_reassembler_ascii_header (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire fra_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output fra_pkg::out_t       out_data_o
);

  logic                 accept;
  logic                 frame_beat;
  logic                 rd_oor;
  logic                 rd_en;
  logic                 s1_go;
  fra_pkg::wr_t         wr;
  fra_pkg::frame_res_t  res;
  logic [7:0]           rdata;

  logic                 s1_v_q;
  logic                 s1_read_q;
  logic                 s1_oor_q;
  fra_pkg::frame_res_t  s1_res_q;
  logic                 out_v_q;
  fra_pkg::out_t        out_q;

  // Handshake and stage flow
  assign s1_go      = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_go;
  assign accept     = in_valid_i && in_ready_o;
  assign frame_beat = accept && !in_data_i.op;
  assign rd_oor     = in_data_i.read_address >= 8'(fra_pkg::StoreSize);
  assign rd_en      = accept && in_data_i.op && !rd_oor;

  fra_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (frame_beat),
    .data_byte_i (in_data_i.data_byte),
    .last_byte_i (in_data_i.last_byte),
    .wr_o        (wr),
    .res_o       (res)
  );

  fra_ram #(
    .WIDTH (8),
    .DEPTH (fra_pkg::StoreSize)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd_en),
    .raddr_i (in_data_i.read_address[fra_pkg::StoreAw-1:0]),
    .rdata_o (rdata)
  );

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_q <= in_data_i.op || res.done;
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
      if (s1_go) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Stage payloads: hold while stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_read_q <= in_data_i.op;
      s1_oor_q  <= rd_oor;
      s1_res_q  <= res;
    end
    if (s1_go) begin
      if (s1_read_q) begin
        out_q.status         <= fra_pkg::StRead;
        out_q.frame_count    <= '0;
        out_q.message_length <= '0;
        out_q.read_data      <= s1_oor_q ? 8'h00 : rdata;
      end else begin
        out_q.status         <= s1_res_q.status;
        out_q.frame_count    <= s1_res_q.frame_count;
        out_q.message_length <= s1_res_q.message_length;
        out_q.read_data      <= 8'h00;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // Checks
  a_read_enters_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.op |=> s1_v_q && s1_read_q)
    else $error("read beat did not enter the read stage");

  a_read_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == fra_pkg::StRead) |->
      (out_data_o.frame_count == 5'd0) && (out_data_o.message_length == 8'd0))
    else $error("read result carries frame fields");

  a_malformed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == fra_pkg::StMalformed) |->
      (out_data_o.frame_count == 5'd0) && (out_data_o.message_length == 8'd0) &&
      (out_data_o.read_data == 8'd0))
    else $error("malformed result carries data");

  a_complete_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == fra_pkg::StComplete) |->
      (out_data_o.frame_count != 5'd0))
    else $error("complete message without frame count");

endmodule

`default_nettype wire

[dv/frame_reassembler_ascii_header_test.sv]
// ----------------------------------------------------------------------------
// frame_reassembler_ascii_header_test: self-checking bench for the reassembler
// Drives frame bytes and store reads through the valid/ready input channel,
// predicts every outcome and read beat in step with accepted beats, and checks
// each result beat field by field. Directed frames cover header, payload,
// dot and completion cases; random messages, noise and reads follow under
// three idle patterns on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_reassembler_ascii_header_test;

  typedef logic [7:0] byte_q_t[$];

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  fra_pkg::in_t   in_beat   = '0;
  logic           in_ready;
  logic           out_valid;
  logic           out_ready = 1'b0;
  fra_pkg::out_t  out_beat;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int read_mix_pct  = 0;
  int beat_cnt      = 0;
  int err_cnt       = 0;

  // Mirror of the reassembler state
  int            rx_pos;
  int            hdr_total;
  int            hdr_index;
  int            pay_cnt;
  bit            hdr_bad;
  bit            pay_ended;
  bit            dot_first;
  bit            one_second;
  logic [7:0]    msg_store     [fra_pkg::StoreSize];
  bit            store_written [fra_pkg::StoreSize];
  bit            frame_seen    [fra_pkg::MaxFrames];
  int            frame_len     [fra_pkg::MaxFrames];
  fra_pkg::out_t outcome_q[$];

  frame_reassembler_ascii_header u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_beat)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stall the result channel at the current idle rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_error(input string what, input int got, input int want);
    err_cnt++;
    $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  function automatic bit header_in_range();
    return !hdr_bad && hdr_total >= 1 && hdr_total <= fra_pkg::MaxFrames &&
           hdr_index < hdr_total;
  endfunction

  // Advance the mirrored state by one beat and build its result, if any
  function automatic void reassemble_beat(input fra_pkg::in_t b, output bit has_res,
                                          output fra_pkg::out_t res);
    int pos;
    int j;
    int addr;
    int digit;
    bit all_seen;
    res = '0;
    has_res = 1'b0;
    if (b.op) begin
      res.status = fra_pkg::StRead;
      if (b.read_address < fra_pkg::StoreSize) res.read_data = msg_store[b.read_address];
      has_res = 1'b1;
      return;
    end
    pos = rx_pos;
    if (pos < fra_pkg::PosLimit) begin
      if (pos < fra_pkg::HdrLen) begin
        if (b.data_byte < fra_pkg::AsciiZero || b.data_byte > fra_pkg::AsciiNine) begin
          hdr_bad = 1'b1;
        end else begin
          digit = int'(b.data_byte - fra_pkg::AsciiZero);
          case (pos)
            0: hdr_total = digit * fra_pkg::DecimalBase;
            1: hdr_total += digit;
            2: hdr_index = digit * fra_pkg::DecimalBase;
            default: hdr_index += digit;
          endcase
        end
      end else if (!pay_ended) begin
        j = pos - fra_pkg::HdrLen;
        if (b.data_byte == 8'h00) begin
          pay_ended = 1'b1;
        end else begin
          if (j == 0 && b.data_byte == fra_pkg::AsciiDot) dot_first = 1'b1;
          if (j == 1 && b.data_byte == fra_pkg::AsciiOne) one_second = 1'b1;
          if (j < fra_pkg::PayloadBytes) begin
            if (header_in_range()) begin
              addr = hdr_index * fra_pkg::PayloadBytes + j;
              msg_store[addr]     = b.data_byte;
              store_written[addr] = 1'b1;
            end
            pay_cnt++;
          end
        end
      end
      rx_pos = pos + 1;
    end
    if (!b.last_byte) return;

    has_res = 1'b1;
    if (rx_pos < fra_pkg::HdrLen || !header_in_range()) begin
      res.status = fra_pkg::StMalformed;
    end else begin
      res.frame_count = 5'(hdr_total);
      frame_seen[hdr_index] = 1'b1;
      frame_len[hdr_index]  = pay_cnt;
      if (dot_first) begin
        res.status = one_second ? fra_pkg::StEndTurn : fra_pkg::StShutdown;
      end else begin
        all_seen = 1'b1;
        for (int i = 0; i < hdr_total; i++) begin
          if (!frame_seen[i]) all_seen = 1'b0;
        end
        if (all_seen) begin
          res.status = fra_pkg::StComplete;
          res.message_length = 8'((hdr_total - 1) * fra_pkg::PayloadBytes +
                                  frame_len[hdr_total - 1]);
          for (int i = 0; i < fra_pkg::MaxFrames; i++) frame_seen[i] = 1'b0;
        end else begin
          res.status = fra_pkg::StIncomplete;
        end
      end
    end
    // Drop the per-frame state
    rx_pos = 0;  hdr_total = 0;  hdr_index = 0;  pay_cnt = 0;
    hdr_bad = 1'b0;  pay_ended = 1'b0;  dot_first = 1'b0;  one_second = 1'b0;
  endfunction

  // Check each result beat against the oldest outstanding outcome
  always @(negedge clk) begin : check_results
    fra_pkg::out_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (outcome_q.size() == 0) begin
        report_error("unexpected result beat, status", int'(out_beat.status), 0);
      end else begin
        want = outcome_q.pop_front();
        if (out_beat.status !== want.status)
          report_error("status", int'(out_beat.status), int'(want.status));
        if (out_beat.frame_count !== want.frame_count)
          report_error("frame_count", int'(out_beat.frame_count), int'(want.frame_count));
        if (out_beat.message_length !== want.message_length)
          report_error("message_length", int'(out_beat.message_length),
                       int'(want.message_length));
        if (out_beat.read_data !== want.read_data)
          report_error("read_data", int'(out_beat.read_data), int'(want.read_data));
      end
    end
  end

  // Offer one beat, hold it until accepted, then predict its result
  task automatic send_beat(input fra_pkg::in_t b);
    bit            has_res;
    fra_pkg::out_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(negedge clk); while (in_ready !== 1'b1);
    @(posedge clk);
    beat_cnt++;
    reassemble_beat(b, has_res, res);
    if (has_res) outcome_q.push_back(res);
  endtask

  task automatic send_byte(input logic [7:0] d, input bit last);
    fra_pkg::in_t b;
    b.op           = 1'b0;
    b.data_byte    = d;
    b.last_byte    = last;
    b.read_address = 8'($urandom_range(255));
    send_beat(b);
  endtask

  task automatic send_read(input logic [7:0] a);
    fra_pkg::in_t b;
    b.op           = 1'b1;
    b.data_byte    = 8'($urandom_range(255));
    b.last_byte    = 1'($urandom_range(1));
    b.read_address = a;
    send_beat(b);
  endtask

  // Pick a written store byte, or an address past the store
  function automatic logic [7:0] pick_read_addr();
    int a;
    if ($urandom_range(4) != 0) begin
      for (int t = 0; t < 24; t++) begin
        a = $urandom_range(fra_pkg::StoreSize - 1);
        if (store_written[a]) return 8'(a);
      end
    end
    return 8'($urandom_range(fra_pkg::StoreSize, 255));
  endfunction

  // Send a frame's bytes, with reads mixed in at the current rate
  task automatic send_raw(input byte_q_t q);
    foreach (q[i]) begin
      if ($urandom_range(99) < read_mix_pct) send_read(pick_read_addr());
      send_byte(q[i], i == q.size() - 1);
    end
  endtask

  task automatic send_frame(input int total, input int index, input byte_q_t pay);
    byte_q_t q;
    q.push_back(fra_pkg::AsciiZero + 8'(total / 10));
    q.push_back(fra_pkg::AsciiZero + 8'(total % 10));
    q.push_back(fra_pkg::AsciiZero + 8'(index / 10));
    q.push_back(fra_pkg::AsciiZero + 8'(index % 10));
    foreach (pay[i]) q.push_back(pay[i]);
    send_raw(q);
  endtask

  // Hold off the input until every outstanding result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outcome_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random payload: mostly plain, some long, some cut by a zero, some dot frames
  task automatic rand_payload(ref byte_q_t pay);
    int kind;
    int n;
    pay.delete();
    kind = $urandom_range(99);
    n = ($urandom_range(9) == 0) ? $urandom_range(11, 13) : $urandom_range(0, 10);
    if (kind < 8) begin
      pay.push_back(fra_pkg::AsciiDot);
      if ($urandom_range(1)) pay.push_back(fra_pkg::AsciiOne);
      else if ($urandom_range(3) != 0) pay.push_back(8'($urandom_range(1, 255)));
    end
    for (int i = 0; i < n; i++) pay.push_back(8'($urandom_range(1, 255)));
    if (kind >= 8 && kind < 20) pay.insert($urandom_range(pay.size()), 8'h00);
  endtask

  // Whole message in shuffled order, now and then with a gap or a repeat
  task automatic send_message();
    int      total;
    int      j;
    int      tmp;
    int      order[$];
    byte_q_t pay;
    total = ($urandom_range(9) == 0) ? $urandom_range(5, fra_pkg::MaxFrames) :
                                       $urandom_range(1, 4);
    for (int i = 0; i < total; i++) order.push_back(i);
    for (int i = total - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];  order[i] = order[j];  order[j] = tmp;
    end
    if (total > 1 && $urandom_range(9) == 0) void'(order.pop_back());
    if ($urandom_range(9) == 0) order.push_front(order[$urandom_range(order.size() - 1)]);
    foreach (order[i]) begin
      rand_payload(pay);
      send_frame(total, order[i], pay);
    end
  endtask

  // Noise, short frames and headers out of range
  task automatic send_broken();
    byte_q_t q;
    byte_q_t pay;
    int      n;
    int      total;
    case ($urandom_range(3))
      0: begin
        n = $urandom_range(1, 16);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(1)) q.push_back(fra_pkg::AsciiZero + 8'($urandom_range(9)));
          else q.push_back(8'($urandom_range(255)));
        end
        send_raw(q);
      end
      1: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) q.push_back(fra_pkg::AsciiZero + 8'($urandom_range(9)));
        send_raw(q);
      end
      2: begin
        rand_payload(pay);
        total = $urandom_range(3) == 0 ? 0 : $urandom_range(fra_pkg::MaxFrames + 1, 99);
        send_frame(total, $urandom_range(99), pay);
      end
      default: begin
        rand_payload(pay);
        total = $urandom_range(1, fra_pkg::MaxFrames);
        send_frame(total, $urandom_range(total, 99), pay);
      end
    endcase
  endtask

  task automatic test_reads_out_of_range();
    send_read(8'(fra_pkg::StoreSize));
    send_read(8'hFF);
  endtask

  task automatic test_message_assembly();
    byte_q_t pay;
    // Second frame first, full payload with byte extremes
    pay = '{8'h01, 8'hFF, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h7E};
    send_frame(2, 1, pay);
    // First frame cut short by a zero byte completes the message
    pay = '{8'h7F, 8'h80, 8'h00, 8'h55};
    send_frame(2, 0, pay);
    send_read(8'd0);
    send_read(8'd10);
    send_read(8'd19);
    // Header-only frame: empty payload
    pay.delete();
    send_frame(1, 0, pay);
    // Read in the middle of a frame
    send_byte(fra_pkg::AsciiZero, 1'b0);
    send_byte(fra_pkg::AsciiOne, 1'b0);
    send_byte(fra_pkg::AsciiZero, 1'b0);
    send_read(8'd11);
    send_byte(fra_pkg::AsciiZero, 1'b0);
    send_byte(8'h5A, 1'b1);
    // Highest frame of the largest message
    pay = '{8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hA5, 8'hA6, 8'hA7, 8'hA8, 8'hA9};
    send_frame(fra_pkg::MaxFrames, fra_pkg::MaxFrames - 1, pay);
    send_read(8'(fra_pkg::StoreSize - 1));
  endtask

  task automatic test_long_payload();
    byte_q_t pay;
    for (int i = 0; i < 14; i++) pay.push_back(8'h61 + 8'(i));
    send_frame(1, 0, pay);
  endtask

  task automatic test_dot_frames();
    byte_q_t pay;
    pay = '{fra_pkg::AsciiDot, fra_pkg::AsciiOne, 8'h78};
    send_frame(2, 0, pay);
    pay = '{fra_pkg::AsciiDot, 8'h32};
    send_frame(2, 1, pay);
    pay = '{fra_pkg::AsciiDot};
    send_frame(1, 0, pay);
    // Marks left by the dot frames let this one complete the message
    pay = '{8'h71};
    send_frame(2, 1, pay);
  endtask

  task automatic test_malformed_headers();
    send_raw('{fra_pkg::AsciiZero, 8'h61, fra_pkg::AsciiZero, fra_pkg::AsciiZero, 8'h78});
    send_raw('{fra_pkg::AsciiZero, fra_pkg::AsciiOne, 8'h00, fra_pkg::AsciiZero});
    send_raw('{8'h2F, fra_pkg::AsciiOne, fra_pkg::AsciiZero, fra_pkg::AsciiZero});
    send_raw('{fra_pkg::AsciiZero, fra_pkg::AsciiOne, fra_pkg::AsciiZero, 8'h3A, 8'h41});
    send_raw('{fra_pkg::AsciiZero, fra_pkg::AsciiOne});
    send_raw('{fra_pkg::AsciiNine});
    send_raw('{fra_pkg::AsciiZero, fra_pkg::AsciiZero, fra_pkg::AsciiZero,
               fra_pkg::AsciiZero, 8'h79});
    send_frame(fra_pkg::MaxFrames + 1, 0, '{8'h42});
    send_raw('{fra_pkg::AsciiNine, fra_pkg::AsciiNine, fra_pkg::AsciiNine,
               fra_pkg::AsciiNine});
    send_frame(2, 2, '{8'h7A});
  endtask

  task automatic test_random_traffic(input int n_beats);
    int stop;
    int r;
    stop = beat_cnt + n_beats;
    read_mix_pct = 6;
    while (beat_cnt < stop) begin
      r = $urandom_range(99);
      if (r < 70) send_message();
      else if (r < 82) repeat ($urandom_range(1, 4)) send_read(pick_read_addr());
      else send_broken();
    end
    read_mix_pct = 0;
  endtask

  // Give up on a hung run
  initial begin
    #8000000;
    $display("FAIL frame_reassembler_ascii_header");
    $finish;
  end

  initial begin : run_tests
    int waited;
    send_idle_pct = 22;
    recv_idle_pct = 66;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reads_out_of_range();
    test_message_assembly();
    test_long_payload();
    test_dot_frames();
    test_malformed_headers();
    wait_idle();

    test_random_traffic(320);
    wait_idle();
    send_idle_pct = 66;
    recv_idle_pct = 22;
    test_random_traffic(320);
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(330);

    // Drain outstanding results, then let the pipeline settle
    in_valid <= 1'b0;
    waited = 0;
    while (outcome_q.size() > 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
    if (outcome_q.size() > 0) report_error("results never arrived", 0, outcome_q.size());
    if (err_cnt == 0) begin
      $display("PASS frame_reassembler_ascii_header");
    end else begin
      $display("FAIL frame_reassembler_ascii_header");
    end
    $finish;
  end

endmodule

`default_nettype wire
